@@ rtl/core/lsre_pkg.sv @@
// Shared types and constants for the logic sample run-length encoder.
package lsre_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned VALUE_W      = 15;
  localparam int unsigned ADDR_W       = 12;
  localparam int unsigned BUF_W        = 13;
  localparam int unsigned POST_W       = 20;
  localparam int unsigned ADDR_SPAN    = 4096;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = 2;
  localparam int unsigned QCNT_W       = 3;
  localparam int unsigned PADDR_W      = 4;

  localparam logic [VALUE_W-1:0]  MAX_COUNT_16 = 15'h7fff;
  localparam logic [VALUE_W-1:0]  MAX_COUNT_8  = 15'h007f;
  localparam logic [SAMPLE_W-1:0] FLAG_16      = 16'h8000;
  localparam logic [SAMPLE_W-1:0] FLAG_8       = 16'h0080;
  localparam logic [POST_W-1:0]   PAIR_WORDS   = 20'd2;

  localparam logic [1:0] REG_SAMPLE_WIDTH = 2'd0;
  localparam logic [1:0] REG_BUFFER_WORDS = 2'd1;
  localparam logic [1:0] REG_POST_TRIGGER = 2'd2;

  // One emitted run: value word, count word and end-of-capture mark.
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] count_word;
    logic [VALUE_W-1:0]  value;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
  } push_t;

endpackage

@@ rtl/core/lsre_front.sv @@
// Front end: accepts samples, tracks the current run and trigger budget, queues pairs.
module lsre_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_width_16,
  input  logic [lsre_pkg::POST_W-1:0]    post_trigger_words,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lsre_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           trigger_seen,
  input  logic                           q_full,
  output lsre_pkg::push_t                push
);

  logic [lsre_pkg::VALUE_W-1:0] run_value, run_count;
  logic [lsre_pkg::POST_W-1:0]  budget_left;
  logic                         after_trigger, finished;

  logic [lsre_pkg::VALUE_W-1:0]  maxc, v, cnt_inc, cnt_raw, cnt_sat;
  logic [lsre_pkg::SAMPLE_W-1:0] flag;
  logic [lsre_pkg::POST_W-1:0]   budget_next, budget_after;
  logic                          trig_next, same, emit, done, accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    maxc    = sample_width_16 ? lsre_pkg::MAX_COUNT_16 : lsre_pkg::MAX_COUNT_8;
    flag    = sample_width_16 ? lsre_pkg::FLAG_16 : lsre_pkg::FLAG_8;
    v       = sample[lsre_pkg::VALUE_W-1:0] & maxc;
    trig_next = after_trigger || trigger_seen;
    budget_next = (trigger_seen && !after_trigger) ?
                  {post_trigger_words[lsre_pkg::POST_W-1:1], 1'b0} : budget_left;
    same    = (v == run_value);
    cnt_inc = run_count + 1'b1;
    cnt_raw = same ? cnt_inc : run_count;
    cnt_sat = (cnt_raw > maxc) ? maxc : cnt_raw;
    emit    = !finished && (!same || (cnt_inc >= maxc));
    done    = trig_next && (budget_next <= lsre_pkg::PAIR_WORDS);
    if (!trig_next || done) begin
      budget_after = trig_next ? '0 : budget_next;
    end else begin
      budget_after = budget_next - lsre_pkg::PAIR_WORDS;
    end
    push.valid           = accept && emit;
    push.pair.done       = done;
    push.pair.value      = run_value;
    push.pair.count_word = {1'b0, cnt_sat} | flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value     <= '0;
      run_count     <= '0;
      budget_left   <= '0;
      after_trigger <= 1'b0;
      finished      <= 1'b0;
    end else if (accept && !finished) begin
      after_trigger <= trig_next;
      if (emit) begin
        budget_left <= budget_after;
        finished    <= done;
        run_count   <= '0;
        if (!same) begin
          run_value <= v;
        end
      end else begin
        budget_left <= budget_next;
        run_count   <= cnt_inc;
      end
    end
  end

endmodule

@@ rtl/core/lsre_queue.sv @@
// Short request queue between the front and back ends.
module lsre_queue (
  input  logic            clk,
  input  logic            rst,
  input  lsre_pkg::push_t push,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output lsre_pkg::pair_t head
);

  lsre_pkg::pair_t                slots [lsre_pkg::QUEUE_DEPTH];
  logic [lsre_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [lsre_pkg::QCNT_W-1:0]    count;
  logic                           do_push, do_pop;

  assign full    = (count == lsre_pkg::QCNT_W'(lsre_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/lsre_back.sv @@
// Back end: splits each queued pair into two store words and advances the address.
module lsre_back #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lsre_pkg::BUF_W-1:0]   buffer_words,
  input  logic                         q_empty,
  input  lsre_pkg::pair_t              head,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);

  localparam int unsigned CAP_INT = (STORE_DEPTH > lsre_pkg::ADDR_SPAN) ?
                                    lsre_pkg::ADDR_SPAN : STORE_DEPTH;
  localparam logic [lsre_pkg::BUF_W-1:0] DEPTH_CAP = lsre_pkg::BUF_W'(CAP_INT);

  logic [lsre_pkg::ADDR_W-1:0]   addr;
  logic [lsre_pkg::BUF_W-1:0]    limit, addr_inc;
  logic [lsre_pkg::ADDR_W-1:0]   addr_next;
  logic [lsre_pkg::SAMPLE_W-1:0] word;
  logic                          second, load;

  always_comb begin
    limit     = (buffer_words > DEPTH_CAP) ? DEPTH_CAP : buffer_words;
    addr_inc  = {1'b0, addr} + 1'b1;
    addr_next = (addr_inc >= limit) ? '0 : addr_inc[lsre_pkg::ADDR_W-1:0];
    word      = second ? head.count_word : {1'b0, head.value};
    load      = !m_tvalid || m_tready;
    pop       = load && !q_empty && second;
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      m_tdata <= {4'b0, word, addr};
      m_tlast <= second;
      m_tuser <= head.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      addr     <= '0;
      second   <= 1'b0;
    end else if (load) begin
      m_tvalid <= !q_empty;
      if (!q_empty) begin
        addr   <= addr_next;
        second <= !second;
      end
    end
  end

endmodule

@@ rtl/core/logic_sample_rle_encoder.sv @@
// Top level of the logic sample run-length encoder with its register port.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[15:0] sample, s_tuser trigger_seen
// m_       out  m_tvalid/m_tready  m_tdata addr/word, m_tlast count word, m_tuser done
// apb      in   psel/penable       paddr[3:2] register, pwdata, prdata
//
// A sample is taken every cycle while the four-entry pair queue has room.
// Each emitted pair leaves as two words, value word then count word; the back end's
// single output register takes the next pair only after both words are loaded.
// Reset clears run state, address and queue; registers return to defaults.
// A stalled output fills the queue, then s_tready drops.
module logic_sample_rle_encoder #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tuser,   // [0] trigger_seen
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [11:0] store_addr, [27:12] store_word, [31:28] zero
  output logic        m_tlast,
  output logic        m_tuser,   // [0] capture_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lsre_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                               sample_width_16;
  logic [lsre_pkg::BUF_W-1:0]         buffer_words;
  logic [lsre_pkg::POST_W-1:0]        post_trigger_words;
  logic [1:0]                         reg_idx;
  logic                               q_full, q_empty, pop;
  lsre_pkg::push_t                    push;
  lsre_pkg::pair_t                    head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      lsre_pkg::REG_SAMPLE_WIDTH: prdata = {31'b0, sample_width_16};
      lsre_pkg::REG_BUFFER_WORDS: prdata = {19'b0, buffer_words};
      lsre_pkg::REG_POST_TRIGGER: prdata = {12'b0, post_trigger_words};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width_16    <= 1'b1;
      buffer_words       <= lsre_pkg::BUF_W'(lsre_pkg::ADDR_SPAN);
      post_trigger_words <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        lsre_pkg::REG_SAMPLE_WIDTH: sample_width_16    <= pwdata[0];
        lsre_pkg::REG_BUFFER_WORDS: buffer_words       <= pwdata[lsre_pkg::BUF_W-1:0];
        lsre_pkg::REG_POST_TRIGGER: post_trigger_words <= pwdata[lsre_pkg::POST_W-1:0];
        default: ;
      endcase
    end
  end

  lsre_front u_front (
    .clk                (clk),
    .rst                (rst),
    .sample_width_16    (sample_width_16),
    .post_trigger_words (post_trigger_words),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .sample             (s_tdata),
    .trigger_seen       (s_tuser),
    .q_full             (q_full),
    .push               (push)
  );

  lsre_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  lsre_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .buffer_words (buffer_words),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

  // value word taken: its count word follows at once
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("count word did not follow value word");

  // both words of a pair carry the same done mark
  a_done_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tuser == $past(m_tuser))
    else $error("capture_done differs within a pair");

  // queue never takes a pair while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full)
    else $error("pair pushed into full queue");

endmodule
